// ===== hdl/rope_pair_rotator_sections_top_assert.svh =====
// assertion macros for the top rtl file
`ifndef ROPE_PAIR_ROTATOR_SECTIONS_TOP_ASSERT_SVH
`define ROPE_PAIR_ROTATOR_SECTIONS_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define RPR_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("rpr assertion failed");

// condition holds in the cycle after the trigger
`define RPR_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("rpr assertion failed");

`endif

// ===== hdl/rpr_pkg.sv =====
package rpr_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int MAX_HALF_DIM  = 64;
  localparam int DATA_W        = 16;
  localparam int COEF_W        = 16;
  localparam int FRAC_BITS     = 14;

  localparam int POS_W       = $clog2(MAX_POSITIONS);
  localparam int PAIR_W      = $clog2(MAX_HALF_DIM);
  localparam int ADDR_W      = POS_W + PAIR_W;
  localparam int TABLE_DEPTH = MAX_POSITIONS * MAX_HALF_DIM;
  localparam int ENTRY_W     = 2 * COEF_W;
  localparam int PROD_W      = DATA_W + COEF_W;
  localparam int SUM_W       = PROD_W + 1;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;

  // input tdata layout, lowest field first
  localparam int IN_PAIR_LSB = 0;
  localparam int IN_X_LSB    = IN_PAIR_LSB + PAIR_W;
  localparam int IN_Y_LSB    = IN_X_LSB + DATA_W;
  localparam int IN_PT_LSB   = IN_Y_LSB + DATA_W;
  localparam int IN_PH_LSB   = IN_PT_LSB + POS_W;
  localparam int IN_PW_LSB   = IN_PH_LSB + POS_W;
  localparam int IN_COS_LSB  = IN_PW_LSB + POS_W;
  localparam int IN_SIN_LSB  = IN_COS_LSB + COEF_W;
  localparam int IN_USED_W   = IN_SIN_LSB + COEF_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * DATA_W + 7) / 8) * 8;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_ROTATE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_DIM       = 3'd0,
    REG_SECTION_TIME   = 3'd1,
    REG_SECTION_HEIGHT = 3'd2,
    REG_SECTION_WIDTH  = 3'd3,
    REG_INTERLEAVE     = 3'd4,
    REG_MULTIMODAL     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] ry;
    logic [DATA_W-1:0] rx;
  } out_item_t;

  // pair index modulo 3: base-4 digits are each worth 1 mod 3
  localparam int MOD_DIGITS = (PAIR_W + 1) / 2;

  function automatic logic [1:0] pair_mod3(input logic [PAIR_W-1:0] p);
    logic [2*MOD_DIGITS-1:0] pp;
    logic [4:0]              acc;
    logic [2:0]              acc2;
    logic [2:0]              acc3;
    pp  = (2 * MOD_DIGITS)'(p);
    acc = '0;
    for (int i = 0; i < MOD_DIGITS; i++) begin
      acc = acc + 5'(pp[2*i +: 2]);
    end
    acc2 = 3'(acc[1:0]) + 3'(acc[3:2]) + 3'(acc[4]);
    acc3 = 3'(acc2[1:0]) + 3'(acc2[2]);
    if (acc3 >= 3'd3) begin
      acc3 = acc3 - 3'd3;
    end
    return acc3[1:0];
  endfunction

endpackage

// ===== hdl/rpr_ram.sv =====
module rpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hdl/rope_pair_rotator_sections_top.sv =====
// channel | direction | handshake                | payload
// s       | in        | s_tvalid / s_tready      | s_tdata fields, s_tuser command
// m       | out       | m_tvalid / m_tready      | m_tdata rotated pair, m_tuser saturated
// cfg     | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one item per cycle while s_tready is high; after its accept a rotate result passes through
// the table read, the multiply stage, and round and saturate into the result queue
// loads produce no result and only use the table write port
// synchronous active high reset clears pipeline valids, the result queue and config
// the cos/sin table is not cleared; entries are undefined until loaded
// s_tready drops only when the 4-entry result queue plus items in flight is full
`include "rope_pair_rotator_sections_top_assert.svh"

module rope_pair_rotator_sections_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pair_index, x_value, y_value, pos_time, pos_height, pos_width, load_cos, load_sin
  input  logic [rpr_pkg::IN_TDATA_W-1:0]    s_tdata,
  // command
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // rotated_x, rotated_y
  output logic [rpr_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // saturated
  output logic                              m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpr_pkg::CFG_W-1:0]         cfg_data
);

  import rpr_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] CLIP_HI    = SUM_W'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] CLIP_LO    = -SUM_W'(1 << (DATA_W - 1));

  // configuration registers
  logic [CFG_W-1:0] half_dim;
  logic [CFG_W-1:0] section_time;
  logic [CFG_W-1:0] section_height;
  logic [CFG_W-1:0] section_width;
  logic             interleave_sections;
  logic             multimodal_on;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_dim            <= CFG_W'(MAX_HALF_DIM);
      section_time        <= CFG_W'(MAX_HALF_DIM);
      section_height      <= '0;
      section_width       <= '0;
      interleave_sections <= 1'b0;
      multimodal_on       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HALF_DIM:       half_dim            <= cfg_data;
        REG_SECTION_TIME:   section_time        <= cfg_data;
        REG_SECTION_HEIGHT: section_height      <= cfg_data;
        REG_SECTION_WIDTH:  section_width       <= cfg_data;
        REG_INTERLEAVE:     interleave_sections <= cfg_data[0];
        REG_MULTIMODAL:     multimodal_on       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input fields
  cmd_t                     cmd;
  logic [PAIR_W-1:0]        pair;
  logic signed [DATA_W-1:0] x_in;
  logic signed [DATA_W-1:0] y_in;
  logic [POS_W-1:0]         pos_t;
  logic [POS_W-1:0]         pos_h;
  logic [POS_W-1:0]         pos_w;
  logic [COEF_W-1:0]        ld_cos;
  logic [COEF_W-1:0]        ld_sin;

  assign cmd    = cmd_t'(s_tuser);
  assign pair   = s_tdata[IN_PAIR_LSB +: PAIR_W];
  assign x_in   = s_tdata[IN_X_LSB +: DATA_W];
  assign y_in   = s_tdata[IN_Y_LSB +: DATA_W];
  assign pos_t  = s_tdata[IN_PT_LSB +: POS_W];
  assign pos_h  = s_tdata[IN_PH_LSB +: POS_W];
  assign pos_w  = s_tdata[IN_PW_LSB +: POS_W];
  assign ld_cos = s_tdata[IN_COS_LSB +: COEF_W];
  assign ld_sin = s_tdata[IN_SIN_LSB +: COEF_W];

  logic accept;
  logic rot_accept;
  assign accept     = s_tvalid && s_tready;
  assign rot_accept = accept && (cmd == CMD_ROTATE);

  // section rule: which position row feeds this pair
  logic [CFG_W:0]   sec_th;
  logic [CFG_W+1:0] sec_h3;
  logic [CFG_W+1:0] sec_w3;
  logic [1:0]       pmod3;
  logic [POS_W-1:0] row;
  logic             pass_through;

  assign sec_th       = (CFG_W + 1)'(section_time) + (CFG_W + 1)'(section_height);
  assign sec_h3       = {1'b0, section_height, 1'b0} + (CFG_W + 2)'(section_height);
  assign sec_w3       = {1'b0, section_width, 1'b0} + (CFG_W + 2)'(section_width);
  assign pmod3        = pair_mod3(pair);
  assign pass_through = CFG_W'(pair) >= half_dim;

  always_comb begin
    priority if (!multimodal_on) begin
      row = pos_t;
    end else if (interleave_sections) begin
      priority if (pmod3 == 2'd1 && (CFG_W + 2)'(pair) < sec_h3) begin
        row = pos_h;
      end else if (pmod3 == 2'd2 && (CFG_W + 2)'(pair) < sec_w3) begin
        row = pos_w;
      end else begin
        row = pos_t;
      end
    end else if (CFG_W'(pair) < section_time) begin
      row = pos_t;
    end else if ((CFG_W + 1)'(pair) < sec_th) begin
      row = pos_h;
    end else begin
      row = pos_w;
    end
  end

  // table: one entry per row and pair, {sin, cos}
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0]  ram_rdata;

  assign ram_we   = (cmd == CMD_LOAD);
  assign ram_addr = (cmd == CMD_LOAD) ? {pos_t, pair} : {row, pair};

  rpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (accept),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({ld_sin, ld_cos}),
    .rdata (ram_rdata)
  );

  // stage 1: table data arrives
  logic                     v1;
  logic                     pass1;
  logic signed [DATA_W-1:0] x1;
  logic signed [DATA_W-1:0] y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= rot_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rot_accept) begin
      pass1 <= pass_through;
      x1    <= x_in;
      y1    <= y_in;
    end
  end

  logic signed [COEF_W-1:0] cos1;
  logic signed [COEF_W-1:0] sin1;
  assign cos1 = ram_rdata[COEF_W-1:0];
  assign sin1 = ram_rdata[ENTRY_W-1:COEF_W];

  // stage 2: four products
  logic                     v2;
  logic                     pass2;
  logic signed [DATA_W-1:0] x2;
  logic signed [DATA_W-1:0] y2;
  logic signed [PROD_W-1:0] p_xc;
  logic signed [PROD_W-1:0] p_ys;
  logic signed [PROD_W-1:0] p_yc;
  logic signed [PROD_W-1:0] p_xs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      pass2 <= pass1;
      x2    <= x1;
      y2    <= y1;
      p_xc  <= x1 * cos1;
      p_ys  <= y1 * sin1;
      p_yc  <= y1 * cos1;
      p_xs  <= x1 * sin1;
    end
  end

  // round half up, shift out the fraction, clip
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] sh_x;
  logic signed [SUM_W-1:0] sh_y;
  logic [DATA_W-1:0]       clip_x;
  logic [DATA_W-1:0]       clip_y;
  logic                    sat_x;
  logic                    sat_y;
  out_item_t               new_item;

  assign sum_x = SUM_W'(p_xc) - SUM_W'(p_ys) + ROUND_BIAS;
  assign sum_y = SUM_W'(p_yc) + SUM_W'(p_xs) + ROUND_BIAS;
  assign sh_x  = sum_x >>> FRAC_BITS;
  assign sh_y  = sum_y >>> FRAC_BITS;

  always_comb begin
    sat_x  = 1'b1;
    sat_y  = 1'b1;
    priority if (sh_x > CLIP_HI) begin
      clip_x = CLIP_HI[DATA_W-1:0];
    end else if (sh_x < CLIP_LO) begin
      clip_x = CLIP_LO[DATA_W-1:0];
    end else begin
      clip_x = sh_x[DATA_W-1:0];
      sat_x  = 1'b0;
    end
    priority if (sh_y > CLIP_HI) begin
      clip_y = CLIP_HI[DATA_W-1:0];
    end else if (sh_y < CLIP_LO) begin
      clip_y = CLIP_LO[DATA_W-1:0];
    end else begin
      clip_y = sh_y[DATA_W-1:0];
      sat_y  = 1'b0;
    end

    if (pass2) begin
      new_item.rx  = x2;
      new_item.ry  = y2;
      new_item.sat = 1'b0;
    end else begin
      new_item.rx  = clip_x;
      new_item.ry  = clip_y;
      new_item.sat = sat_x || sat_y;
    end
  end

  // result queue; credit covers items still in the pipe so it never overflows
  out_item_t            q_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] count;
  logic [OUT_CNT_W-1:0] count_next;
  logic [OUT_CNT_W-1:0] occupancy;
  logic                 push;
  logic                 pop;
  out_item_t            head;

  assign push      = v2;
  assign pop       = m_tvalid && m_tready;
  assign occupancy = count + OUT_CNT_W'(v1) + OUT_CNT_W'(v2);
  assign s_tready  = occupancy < OUT_CNT_W'(OUT_DEPTH);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_item;
    end
  end

  assign head     = q_mem[rd_ptr];
  assign m_tvalid = (count != '0);
  assign m_tdata  = OUT_TDATA_W'({head.ry, head.rx});
  assign m_tuser  = head.sat;

  // checks
  `RPR_ASSERT_SAME(a_credit_bound, clk, rst, 1'b1, occupancy <= OUT_CNT_W'(OUT_DEPTH))
  `RPR_ASSERT_SAME(a_push_has_room, clk, rst, push && !pop, count < OUT_CNT_W'(OUT_DEPTH))
  `RPR_ASSERT_NEXT(a_rotate_enters, clk, rst, rot_accept, v1)
  `RPR_ASSERT_NEXT(a_stage_moves, clk, rst, v1, v2 && count != '0 || v2)
  `RPR_ASSERT_NEXT(a_result_queued, clk, rst, v2, m_tvalid)

endmodule
